### rtl/bqd_pkg.sv
// shared types and constants for the biquad section
`timescale 1ns / 1ps

package bqd_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A0,
    ST_A1,
    ST_A2,
    ST_B1,
    ST_B2,
    ST_WB
  } bqd_state_t;

endpackage

### rtl/biquad_filter_df2t_unit.sv
// biquad iir section, transposed direct form ii, one shared multiplier
`timescale 1ns / 1ps

// usage
//   input channel: in_valid / in_stall / in_sample_in, one signed sample per transfer
//   result channel: out_valid / out_stall / out_sample_out, one filtered sample
//     per input transfer, in order
//   config port: cfg_wr_en / cfg_index / cfg_wdata write coef a0, a1, a2, b1, b2
//     (index 0..4, higher indexes dropped); write only while the block is idle
// sequence
//   from its transfer to the result register, a sample passes these steps: the
//   five products go one per cycle through a single signed multiplier, one
//   product stage, then the state write-back
//   in_stall is high while a sample is in flight, so a new sample is taken
//   only after the last one has been written back
// stalls
//   the result register is separate from the datapath, so a new sample is taken
//   while the last result still waits; the write-back step holds (and in_stall
//   stays high) only if the previous result has not been taken yet
// reset
//   rst_n (synchronous, active low) clears the handshake state and both delay
//   accumulators and loads a0 = 1.0, other coefs 0

module biquad_filter_df2t_unit
  import bqd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input  logic                           cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [COEF_WIDTH-1:0]          cfg_wdata
);

  // widths: products are exact, accumulators carry two guard bits
  localparam int ACC_W  = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int SUM_W  = ACC_W + 2;
  localparam int FRAC_W = COEF_WIDTH - 4;

  localparam logic signed [SUM_W-1:0]        RND_HALF = SUM_W'(1) << (FRAC_W - 1);
  localparam logic signed [COEF_WIDTH-1:0]   A0_RESET = COEF_WIDTH'(1) << FRAC_W;
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX    = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN    = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]        D_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]        D_MIN    = {1'b1, {(ACC_W-1){1'b0}}};

  bqd_state_t state_r, state_nxt;

  // coefficient registers
  logic signed [COEF_WIDTH-1:0] coef_a0_r, coef_a1_r, coef_a2_r, coef_b1_r, coef_b2_r;

  // delay state
  logic signed [ACC_W-1:0] delay_one_r, delay_one_nxt;
  logic signed [ACC_W-1:0] delay_two_r, delay_two_nxt;

  // datapath
  logic signed [SAMPLE_WIDTH-1:0] x_r, x_nxt;
  logic signed [SAMPLE_WIDTH-1:0] y_r, y_nxt;
  logic signed [ACC_W-1:0]        prod_r, prod_nxt;
  logic signed [SUM_W-1:0]        acc_r, acc_nxt;
  logic signed [SUM_W-1:0]        acc2_r, acc2_nxt;

  // output register
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;

  // shared multiplier operands
  logic signed [SAMPLE_WIDTH-1:0] mul_x;
  logic signed [COEF_WIDTH-1:0]   mul_c;
  logic signed [ACC_W-1:0]        mul_p;

  logic signed [SUM_W-1:0]        prod_ext;
  logic signed [SUM_W-1:0]        rnd_sum;
  logic [SUM_W-FRAC_W-1:0]        y_wide;
  logic [SUM_W-FRAC_W-SAMPLE_WIDTH:0] y_top;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic signed [SUM_W-1:0]        n2_sum;
  logic signed [ACC_W-1:0]        n1_sat, n2_sat;
  logic [SUM_W-ACC_W:0]           n1_top, n2_top;

  logic in_xfer, out_xfer, out_free;

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  // result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  assign mul_p    = mul_x * mul_c;
  assign prod_ext = {{2{prod_r[ACC_W-1]}}, prod_r};

  // round half up, floor shift by the coef fraction bits, clamp to sample range
  assign rnd_sum = acc_r + RND_HALF;
  assign y_wide  = rnd_sum[SUM_W-1:FRAC_W];
  assign y_top   = y_wide[SUM_W-FRAC_W-1:SAMPLE_WIDTH-1];
  always_comb begin
    if (&y_top || ~|y_top) begin
      y_sat = y_wide[SAMPLE_WIDTH-1:0];
    end else if (y_top[SUM_W-FRAC_W-SAMPLE_WIDTH]) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = Y_MAX;
    end
  end

  // state saturation to the accumulator width
  assign n2_sum = acc2_r - prod_ext;
  assign n1_top = acc_r[SUM_W-1:ACC_W-1];
  assign n2_top = n2_sum[SUM_W-1:ACC_W-1];
  always_comb begin
    if (&n1_top || ~|n1_top) begin
      n1_sat = acc_r[ACC_W-1:0];
    end else if (n1_top[SUM_W-ACC_W]) begin
      n1_sat = D_MIN;
    end else begin
      n1_sat = D_MAX;
    end
    if (&n2_top || ~|n2_top) begin
      n2_sat = n2_sum[ACC_W-1:0];
    end else if (n2_top[SUM_W-ACC_W]) begin
      n2_sat = D_MIN;
    end else begin
      n2_sat = D_MAX;
    end
  end

  // sequencer: one product per step, accumulate the previous product
  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    acc2_nxt       = acc2_r;
    delay_one_nxt  = delay_one_r;
    delay_two_nxt  = delay_two_r;
    out_valid_nxt  = out_valid_r && !out_xfer;
    out_sample_nxt = out_sample_r;
    mul_x          = x_r;
    mul_c          = coef_a0_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          x_nxt     = in_sample_in;
          acc_nxt   = {{2{delay_one_r[ACC_W-1]}}, delay_one_r};
          state_nxt = ST_A0;
        end
      end
      ST_A0: begin
        // x * a0
        prod_nxt  = mul_p;
        state_nxt = ST_A1;
      end
      ST_A1: begin
        // acc = x*a0 + z1, start x * a1
        acc_nxt   = acc_r + prod_ext;
        mul_c     = coef_a1_r;
        prod_nxt  = mul_p;
        state_nxt = ST_A2;
      end
      ST_A2: begin
        // y from acc, n1 = x*a1 + z2, start x * a2
        y_nxt     = y_sat;
        acc_nxt   = {{2{delay_two_r[ACC_W-1]}}, delay_two_r} + prod_ext;
        mul_c     = coef_a2_r;
        prod_nxt  = mul_p;
        state_nxt = ST_B1;
      end
      ST_B1: begin
        // n2 = x*a2, start y * b1
        acc2_nxt  = prod_ext;
        mul_x     = y_r;
        mul_c     = coef_b1_r;
        prod_nxt  = mul_p;
        state_nxt = ST_B2;
      end
      ST_B2: begin
        // n1 -= y*b1, start y * b2
        acc_nxt   = acc_r - prod_ext;
        mul_x     = y_r;
        mul_c     = coef_b2_r;
        prod_nxt  = mul_p;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        // n2 -= y*b2, saturate both delays, hand off the result
        if (out_free) begin
          delay_one_nxt  = n1_sat;
          delay_two_nxt  = n2_sat;
          out_valid_nxt  = 1'b1;
          out_sample_nxt = y_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      delay_one_r <= '0;
      delay_two_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      delay_one_r <= delay_one_nxt;
      delay_two_r <= delay_two_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    acc2_r       <= acc2_nxt;
    out_sample_r <= out_sample_nxt;
  end

  // coefficient writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a0_r <= A0_RESET;
      coef_a1_r <= '0;
      coef_a2_r <= '0;
      coef_b1_r <= '0;
      coef_b2_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_A0:  coef_a0_r <= cfg_wdata;
        REG_A1:  coef_a1_r <= cfg_wdata;
        REG_A2:  coef_a2_r <= cfg_wdata;
        REG_B1:  coef_b1_r <= cfg_wdata;
        REG_B2:  coef_b2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

### verif/tb_biquad_filter_df2t_unit.sv
// self-checking testbench for the biquad section: directed table, then random coefficient phases
`timescale 1ns / 1ps

module tb_biquad_filter_df2t_unit
  import bqd_pkg::*;
();

  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 32;
  localparam int ACC_W        = SAMPLE_W + COEF_W;
  localparam int FRAC_BITS    = COEF_W - 4;
  localparam int RANDOM_ITEMS = 1700;
  localparam int SHOW_LIMIT   = 10;
  localparam int IDLE_PCT     = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // one directed row is either a coefficient write or a sample transfer
  typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    cfg_idx_t         idx;
    logic [COEF_W-1:0] data;
    sample_t          smp;
    bit               typed;   // expected value typed in below
    sample_t          want;
  } row_t;

  logic                clk;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  sample_t             in_sample_in = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  sample_t             out_sample_out;
  logic                cfg_wr_en    = 1'b0;
  cfg_idx_t            cfg_index    = '0;
  logic [COEF_W-1:0]   cfg_wdata    = '0;

  // quiet stretch: neither side idles while this is set
  logic                calm         = 1'b0;

  // filter image kept in step with every accepted transfer
  logic signed [COEF_W-1:0] tap_coef [5];
  logic signed [ACC_W-1:0]  acc_z1;
  logic signed [ACC_W-1:0]  acc_z2;

  sample_t expected_samples [$];
  sample_t want_sample;
  row_t    plan [$];
  int      bad_count = 0;

  biquad_filter_df2t_unit #(
    .SAMPLE_WIDTH (SAMPLE_W),
    .COEF_WIDTH   (COEF_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clamp to a signed range of w bits
  function automatic longint sat(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one step of the transposed df2 section; updates the delay image
  function automatic sample_t filter_step(input sample_t x);
    longint xs;
    longint acc;
    longint rnd;
    longint y;
    longint n1;
    longint n2;
    xs  = longint'(x);
    acc = xs * longint'(tap_coef[REG_A0]) + longint'(acc_z1);
    // add half an lsb, then floor: ties go toward plus infinity
    rnd = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    y   = sat(rnd, SAMPLE_W);
    // the clamped output is what feeds back
    n1  = xs * longint'(tap_coef[REG_A1]) + longint'(acc_z2)
          - longint'(tap_coef[REG_B1]) * y;
    n2  = xs * longint'(tap_coef[REG_A2]) - longint'(tap_coef[REG_B2]) * y;
    acc_z1 = ACC_W'(sat(n1, ACC_W));
    acc_z2 = ACC_W'(sat(n2, ACC_W));
    return sample_t'(y);
  endfunction

  function automatic int span(input int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic void plan_write(input cfg_idx_t idx, input logic [COEF_W-1:0] data);
    row_t r;
    r = '{kind: ROW_WRITE, idx: idx, data: data, smp: '0, typed: 1'b0, want: '0};
    plan.push_back(r);
  endfunction

  function automatic void plan_sample(input sample_t x, input bit typed, input sample_t want);
    row_t r;
    r = '{kind: ROW_SAMPLE, idx: '0, data: '0, smp: x, typed: typed, want: want};
    plan.push_back(r);
  endfunction

  // write one coefficient; the enable stays high until the next transfer lowers it
  task automatic write_coef(input cfg_idx_t idx, input logic [COEF_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx <= REG_B2) tap_coef[idx] = val;
  endtask

  // one input transfer, with a random idle gap ahead of it
  task automatic send_sample(input sample_t x, input bit typed, input sample_t want);
    sample_t y;
    cfg_wr_en <= 1'b0;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < IDLE_PCT);
    end
    in_valid     <= 1'b1;
    in_sample_in <= x;
    do @(posedge clk); while (in_stall);
    y = filter_step(x);
    expected_samples.push_back(typed ? want : y);
  endtask

  // stop sending and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  // result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        bad_count++;
        if (bad_count <= SHOW_LIMIT)
          $display("unexpected result transfer: sample_out %0d", out_sample_out);
      end else begin
        want_sample = expected_samples.pop_front();
        if (out_sample_out !== want_sample) begin
          bad_count++;
          if (bad_count <= SHOW_LIMIT)
            $display("sample_out mismatch: expected %0d, got %0d",
                     want_sample, out_sample_out);
        end
      end
    end
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  initial begin : stimulus
    int               phase;
    int               sent;
    int               n;
    int               lim;
    int               coef_val [5];
    sample_t          x;
    cfg_idx_t         k;

    tap_coef[REG_A0] = 32'sh1000_0000;
    tap_coef[REG_A1] = '0;
    tap_coef[REG_A2] = '0;
    tap_coef[REG_B1] = '0;
    tap_coef[REG_B2] = '0;
    acc_z1 = '0;
    acc_z2 = '0;

    // reset values: a0 = 1.0, so the output is the input
    plan_sample(0, 1, 0);
    plan_sample(32767, 1, 32767);
    plan_sample(-32768, 1, -32768);
    plan_sample(1, 1, 1);
    plan_sample(-1, 1, -1);
    // largest positive gain: output saturates at both ends
    plan_write(REG_A0, 32'h7fff_ffff);
    plan_sample(32767, 1, 32767);
    plan_sample(-32768, 1, -32768);
    // most negative gain: signs flip and saturate
    plan_write(REG_A0, 32'h8000_0000);
    plan_sample(32767, 1, -32768);
    plan_sample(-32768, 1, 32767);
    // half gain: rounding of exact halves goes toward plus infinity
    plan_write(REG_A0, 32'h0800_0000);
    plan_sample(1, 1, 1);
    plan_sample(-1, 1, 0);
    plan_sample(3, 1, 2);
    plan_sample(-3, 1, -1);
    // writes beyond the last register are dropped
    for (int i = REG_B2 + 1; i < (1 << CFG_IDX_W); i++) plan_write(cfg_idx_t'(i), '1);
    plan_sample(5, 0, 0);
    // a moderate filter with feedback
    plan_write(REG_A1, 32'h1000_0000);
    plan_write(REG_A2, 32'h0800_0000);
    plan_write(REG_B1, 32'hf400_0000);
    plan_write(REG_B2, 32'h0400_0000);
    plan_sample(1000, 0, 0);
    plan_sample(-2000, 0, 0);
    plan_sample(32767, 0, 0);
    plan_sample(16'sh5a5a, 0, 0);
    plan_sample(-16'sh5a5b, 0, 0);
    // every tap at its extreme: the delay accumulators saturate
    plan_write(REG_A0, 32'h7fff_ffff);
    plan_write(REG_A1, 32'h7fff_ffff);
    plan_write(REG_A2, 32'h7fff_ffff);
    plan_write(REG_B1, 32'h8000_0000);
    plan_write(REG_B2, 32'h8000_0000);
    for (int i = 0; i < 3; i++) plan_sample(32767, 0, 0);
    for (int i = 0; i < 3; i++) plan_sample(-32768, 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        write_coef(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].smp, plan[i].typed, plan[i].want);
      end
    end

    // random part: each phase loads a fresh coefficient set, then streams samples
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      calm <= (phase >= 3 && phase < 7);
      case ((phase < 4) ? phase : $urandom_range(3))
        0: begin
          // fully random taps, mostly unstable and saturating
          foreach (coef_val[j]) coef_val[j] = $urandom;
        end
        1: begin
          // stable second-order section: |b2| < 0.9, |b1| <= 0.9 * (1 + b2)
          coef_val[REG_B2] = span(241591910);
          lim = ((268435456 + coef_val[REG_B2]) / 10) * 9;
          coef_val[REG_B1] = span(lim);
          coef_val[REG_A0] = span(134217728);
          coef_val[REG_A1] = span(134217728);
          coef_val[REG_A2] = span(134217728);
        end
        2: begin
          foreach (coef_val[j]) begin
            case ($urandom_range(4))
              0: coef_val[j] = 32'h7fff_ffff;
              1: coef_val[j] = 32'h8000_0000;
              2: coef_val[j] = 0;
              3: coef_val[j] = 32'h1000_0000;
              default: coef_val[j] = 32'hf000_0000;
            endcase
          end
        end
        default: begin
          foreach (coef_val[j]) coef_val[j] = int'($urandom) >>> $urandom_range(8);
        end
      endcase
      for (int j = REG_A0; j <= REG_B2; j++) write_coef(cfg_idx_t'(j), coef_val[j]);
      if ($urandom_range(3) == 0) begin
        k = cfg_idx_t'(REG_B2 + 1 + $urandom_range(2));
        write_coef(k, $urandom);
      end
      n = $urandom_range(90, 10);
      for (int j = 0; j < n; j++) begin
        case ($urandom_range(19))
          0, 1, 2: begin
            case ($urandom_range(4))
              0: x = 16'sh7fff;
              1: x = 16'sh8000;
              2: x = 16'sh0000;
              3: x = 16'sh0001;
              default: x = 16'shffff;
            endcase
          end
          3, 4, 5, 6, 7: x = sample_t'(int'($urandom_range(512)) - 256);
          default: x = sample_t'($urandom);
        endcase
        send_sample(x, 0, '0);
      end
      sent += n;
      phase++;
    end

    drain();
    calm <= 1'b0;
    // let any stray result show up before the verdict
    repeat (20) @(posedge clk);
    if (bad_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
